// ===== rtl/edns_option_subnet_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// EDNS subnet parser assertion macros
// Shared property templates for the concurrent checks of the parser unit.
// ----------------------------------------------------------------------------
`ifndef EDNS_OPTION_SUBNET_PARSER_UNIT_ASSERT_SVH
`define EDNS_OPTION_SUBNET_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define EOSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define EOSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/eosp_pkg.sv =====
// ----------------------------------------------------------------------------
// EDNS subnet parser package
// Types and constants shared by the stages of the subnet option parser.
// ----------------------------------------------------------------------------
package eosp_pkg;

   // Stored address bytes of a subnet option.
   localparam int ADDR_BYTES  = 16;
   localparam int ADDR_IDX_W  = $clog2(ADDR_BYTES);

   localparam logic [15:0] SUBNET_CODE_RESET  = 16'd8;
   localparam logic [15:0] SUBNET_FIXED_BYTES = 16'd4;
   localparam logic [15:0] FAMILY_IPV4        = 16'd1;
   localparam logic [15:0] FAMILY_IPV6        = 16'd2;
   localparam logic [7:0]  IPV4_MAX_PREFIX    = 8'd32;
   localparam logic [7:0]  IPV6_MAX_PREFIX    = 8'd128;
   localparam logic [15:0] IPV4_ADDR_BYTES    = 16'd4;
   localparam logic [15:0] IPV6_ADDR_BYTES    = 16'(ADDR_BYTES);

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_SHORT_HEADER = 4'd1,
      ST_OVERRUN      = 4'd2,
      ST_SHORT_OPTION = 4'd3,
      ST_BAD_IPV4     = 4'd4,
      ST_BAD_IPV6     = 4'd5,
      ST_BAD_FAMILY   = 4'd6,
      ST_LEN_MISMATCH = 4'd7,
      ST_PAD_BITS     = 4'd8
   } status_type;

   typedef struct packed {
      logic       last_byte;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [63:0] address_low;
      logic [63:0] address_high;
      logic [7:0]  scope_prefix;
      logic [7:0]  source_prefix;
      logic [1:0]  address_family;
      logic        subnet_found;
      status_type  status;
   } result_type;

endpackage

// ===== rtl/edns_option_subnet_parser_unit.sv =====
// ----------------------------------------------------------------------------
// EDNS client subnet option parser
// Takes the RDATA of an EDNS OPT record one byte per item, walks its options
// and reports, on the last byte, the first error and the last valid subnet.
// ----------------------------------------------------------------------------
//
//   Port group | Dir | Contents
//   -----------+-----+-------------------------------------------------------
//   req_*      | in  | one RDATA byte per item, tlast marks the final byte
//   rsp_*      | out | one frame result per item, only after a final byte
//   csr_*      | in  | write of the client subnet option code
//
// The unit accepts one byte per cycle while no final byte waits in the input
// register. A byte is registered at the input, then runs through the parser
// logic. Frame results are held in the result register behind rsp_tvalid.
// Reset is synchronous and clears all parser state at once; the option code
// register returns to 8. There is no initialization sweep.
// While a result waits on rsp_tready, non-final bytes keep flowing; a final
// byte waits in the input register until the result register frees up.
//
`include "edns_option_subnet_parser_unit_assert.svh"

module edns_option_subnet_parser_unit (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] data_byte
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] status, [4] subnet_found, [6:5] address_family,
   // [14:7] source_prefix, [22:15] scope_prefix, [86:23] address_high,
   // [150:87] address_low, [151] zero
   output logic [151:0] rsp_tdata,

   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);

   // The option code that marks a client subnet option. The user must write it
   // only while no frame is in flight; the unit itself does not enforce this.
   logic [15:0] subnet_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         subnet_code_ff <= eosp_pkg::SUBNET_CODE_RESET;
      end else if (csr_we) begin
         subnet_code_ff <= csr_wdata;
      end
   end

   eosp_pkg::item_type   req_item;
   eosp_pkg::item_type   stage_item;
   logic                 stage_valid;
   logic                 stage_take;
   logic                 out_ready;
   logic                 res_valid;
   eosp_pkg::result_type res;
   eosp_pkg::result_type rsp_item;

   assign req_item.data_byte = req_tdata;
   assign req_item.last_byte = req_tlast;

   // Input register: holds the byte the parser works on next.
   eosp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (req_item),
      .take        (stage_take),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   // Parser: option walk, subnet checks and frame result, one byte a cycle but for a stalled final byte.
   eosp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .subnet_code (subnet_code_ff),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .take        (stage_take),
      .out_ready   (out_ready),
      .res_valid   (res_valid),
      .res         (res)
   );

   // Result register: decouples the result from the byte stream.
   eosp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_ready (out_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {1'b0,
                       rsp_item.address_low,
                       rsp_item.address_high,
                       rsp_item.scope_prefix,
                       rsp_item.source_prefix,
                       rsp_item.address_family,
                       rsp_item.subnet_found,
                       rsp_item.status};

   // A result only appears after the parser has consumed a final byte.
   `EOSP_ASSERT_NOW(a_rsp_from_last, clock, reset, $rose(rsp_tvalid), $past(stage_take && stage_item.last_byte), "result appeared without a final byte")

   // A byte that the parser does not take stays in the input register.
   `EOSP_ASSERT_NEXT(a_stage_holds, clock, reset, stage_valid && !stage_take, stage_valid, "input byte lost while stalled")

   // Without a found subnet every subnet field of the result is zero.
   `EOSP_ASSERT_NOW(a_empty_subnet, clock, reset, rsp_tvalid && !rsp_item.subnet_found, rsp_tdata[150:5] == 146'd0, "subnet fields set without a found subnet")

endmodule

// ===== rtl/eosp_in_stage.sv =====
// ----------------------------------------------------------------------------
// EDNS subnet parser input stage
// Registers one incoming byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module eosp_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  eosp_pkg::item_type in_item,
   input  logic               take,
   output logic               stage_valid,
   output eosp_pkg::item_type stage_item
);

   logic               valid_ff;
   logic               valid_in;
   eosp_pkg::item_type item_ff;

   // The slot is free when empty or when its byte leaves this cycle.
   assign in_ready = !valid_ff || take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// ===== rtl/eosp_parser.sv =====
// ----------------------------------------------------------------------------
// EDNS subnet parser core
// Walks the option headers and data, checks a client subnet option when its
// data ends and forms the frame result on the last byte.
// ----------------------------------------------------------------------------
module eosp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          subnet_code,
   input  logic                 stage_valid,
   input  eosp_pkg::item_type   stage_item,
   output logic                 take,
   input  logic                 out_ready,
   output logic                 res_valid,
   output eosp_pkg::result_type res
);

   logic                 in_data_ff, in_data_in;
   logic [1:0]           hdr_cnt_ff, hdr_cnt_in;
   logic [15:0]          option_id_ff, option_id_in;
   logic [15:0]          length_ff, length_in;
   logic [15:0]          data_cnt_ff, data_cnt_in;
   logic [15:0]          family_ff, family_in;
   logic [7:0]           source_ff, source_in;
   logic [7:0]           scope_ff, scope_in;
   logic [7:0]           store_ff [eosp_pkg::ADDR_BYTES];
   logic [7:0]           store_in [eosp_pkg::ADDR_BYTES];
   eosp_pkg::status_type error_ff, error_in;
   logic                 found_ff, found_in;
   logic [17:0]          sub_info_ff, sub_info_in;
   logic [63:0]          sub_high_ff, sub_high_in;
   logic [63:0]          sub_low_ff, sub_low_in;

   logic                 code_hit;
   logic                 finish;
   logic                 frame_end;
   eosp_pkg::status_type walk_error;
   logic [15:0]          addr_off;
   logic [15:0]          n_bytes;
   logic [8:0]           src_sum;
   logic [15:0]          need;
   logic [7:0]           pad_mask;
   eosp_pkg::status_type chk;
   logic [7:0]           b;
   logic [63:0]          high_w, low_w;

   // A last byte needs the result slot; other bytes always move on.
   assign take      = stage_valid && (!stage_item.last_byte || out_ready);
   assign frame_end = take && stage_item.last_byte;
   assign b         = stage_item.data_byte;
   assign code_hit  = (option_id_ff == subnet_code);
   assign addr_off  = data_cnt_ff - eosp_pkg::SUBNET_FIXED_BYTES;

   // Option walk.
   always_comb begin
      in_data_in   = in_data_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      option_id_in = option_id_ff;
      length_in    = length_ff;
      data_cnt_in  = data_cnt_ff;
      family_in    = family_ff;
      source_in    = source_ff;
      scope_in     = scope_ff;
      store_in     = store_ff;
      finish       = 1'b0;
      walk_error   = error_ff;
      if (take && error_ff == eosp_pkg::ST_OK) begin
         if (!in_data_ff) begin
            case (hdr_cnt_ff)
               2'd0: option_id_in = {b, 8'h00};
               2'd1: option_id_in = {option_id_ff[15:8], b};
               2'd2: length_in    = {b, 8'h00};
               default: length_in = {length_ff[15:8], b};
            endcase
            if (hdr_cnt_ff != 2'd3) begin
               hdr_cnt_in = hdr_cnt_ff + 2'd1;
               if (stage_item.last_byte) begin
                  walk_error = eosp_pkg::ST_SHORT_HEADER;
               end
            end else begin
               hdr_cnt_in  = 2'd0;
               data_cnt_in = 16'd0;
               family_in   = 16'd0;
               source_in   = 8'd0;
               scope_in    = 8'd0;
               for (int i = 0; i < eosp_pkg::ADDR_BYTES; i++) begin
                  store_in[i] = 8'd0;
               end
               if (length_in == 16'd0) begin
                  finish = 1'b1;
               end else begin
                  in_data_in = 1'b1;
                  if (stage_item.last_byte) begin
                     walk_error = eosp_pkg::ST_OVERRUN;
                  end
               end
            end
         end else begin
            if (code_hit) begin
               case (data_cnt_ff)
                  16'd0: family_in = {b, 8'h00};
                  16'd1: family_in = {family_ff[15:8], b};
                  16'd2: source_in = b;
                  16'd3: scope_in  = b;
                  default: begin
                     if (addr_off < eosp_pkg::IPV6_ADDR_BYTES) begin
                        store_in[addr_off[eosp_pkg::ADDR_IDX_W-1:0]] = b;
                     end
                  end
               endcase
            end
            data_cnt_in = data_cnt_ff + 16'd1;
            if (data_cnt_in == length_ff) begin
               in_data_in = 1'b0;
               finish     = 1'b1;
            end else if (stage_item.last_byte) begin
               walk_error = eosp_pkg::ST_OVERRUN;
            end
         end
      end
   end

   // Subnet option checks, in priority order. When the data ends with an
   // address byte, that byte is the one on the input now.
   assign n_bytes  = length_in - eosp_pkg::SUBNET_FIXED_BYTES;
   assign src_sum  = {1'b0, source_in} + 9'd7;
   assign need     = {10'd0, src_sum[8:3]};
   assign pad_mask = 8'hff >> source_in[2:0];

   always_comb begin
      chk = eosp_pkg::ST_OK;
      if (length_in < eosp_pkg::SUBNET_FIXED_BYTES) begin
         chk = eosp_pkg::ST_SHORT_OPTION;
      end else if (family_in == eosp_pkg::FAMILY_IPV4 &&
                   (source_in > eosp_pkg::IPV4_MAX_PREFIX || scope_in != 8'd0 ||
                    n_bytes > eosp_pkg::IPV4_ADDR_BYTES)) begin
         chk = eosp_pkg::ST_BAD_IPV4;
      end else if (family_in == eosp_pkg::FAMILY_IPV6 &&
                   (source_in > eosp_pkg::IPV6_MAX_PREFIX || scope_in != 8'd0 ||
                    n_bytes > eosp_pkg::IPV6_ADDR_BYTES)) begin
         chk = eosp_pkg::ST_BAD_IPV6;
      end else if (family_in != eosp_pkg::FAMILY_IPV4 &&
                   family_in != eosp_pkg::FAMILY_IPV6) begin
         chk = eosp_pkg::ST_BAD_FAMILY;
      end else if (need != n_bytes) begin
         chk = eosp_pkg::ST_LEN_MISMATCH;
      end else if (source_in[2:0] != 3'd0 && n_bytes != 16'd0 &&
                   (b & pad_mask) != 8'd0) begin
         chk = eosp_pkg::ST_PAD_BITS;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         high_w[63-8*i -: 8] = store_in[i];
         low_w[63-8*i -: 8]  = store_in[i+8];
      end
   end

   // Subnet capture and frame result.
   always_comb begin
      found_in    = found_ff;
      sub_info_in = sub_info_ff;
      sub_high_in = sub_high_ff;
      sub_low_in  = sub_low_ff;
      error_in    = walk_error;
      res_valid   = 1'b0;
      res         = '0;
      if (finish && code_hit) begin
         if (chk != eosp_pkg::ST_OK) begin
            found_in    = 1'b0;
            sub_info_in = 18'd0;
            sub_high_in = 64'd0;
            sub_low_in  = 64'd0;
            error_in    = chk;
         end else begin
            found_in    = 1'b1;
            sub_info_in = {family_in[1:0], source_in, scope_in};
            sub_high_in = high_w;
            sub_low_in  = low_w;
         end
      end
      if (frame_end) begin
         res_valid        = 1'b1;
         res.status       = error_in;
         res.subnet_found = found_in;
         if (found_in) begin
            res.address_family = sub_info_in[17:16];
            res.source_prefix  = sub_info_in[15:8];
            res.scope_prefix   = sub_info_in[7:0];
            res.address_high   = sub_high_in;
            res.address_low    = sub_low_in;
         end
      end
   end

   // A final byte returns the parser to its idle state, as reset does.
   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         in_data_ff   <= 1'b0;
         hdr_cnt_ff   <= 2'd0;
         option_id_ff <= 16'd0;
         length_ff    <= 16'd0;
         data_cnt_ff  <= 16'd0;
         family_ff    <= 16'd0;
         source_ff    <= 8'd0;
         scope_ff     <= 8'd0;
         for (int i = 0; i < eosp_pkg::ADDR_BYTES; i++) begin
            store_ff[i] <= 8'd0;
         end
         error_ff     <= eosp_pkg::ST_OK;
         found_ff     <= 1'b0;
         sub_info_ff  <= 18'd0;
         sub_high_ff  <= 64'd0;
         sub_low_ff   <= 64'd0;
      end else begin
         in_data_ff   <= in_data_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         option_id_ff <= option_id_in;
         length_ff    <= length_in;
         data_cnt_ff  <= data_cnt_in;
         family_ff    <= family_in;
         source_ff    <= source_in;
         scope_ff     <= scope_in;
         store_ff     <= store_in;
         error_ff     <= error_in;
         found_ff     <= found_in;
         sub_info_ff  <= sub_info_in;
         sub_high_ff  <= sub_high_in;
         sub_low_ff   <= sub_low_in;
      end
   end

endmodule

// ===== rtl/eosp_out_stage.sv =====
// ----------------------------------------------------------------------------
// EDNS subnet parser output stage
// Holds one frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module eosp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  eosp_pkg::result_type res,
   output logic                 out_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output eosp_pkg::result_type rsp_item
);

   logic                 valid_ff;
   logic                 valid_in;
   eosp_pkg::result_type item_ff;

   // A new result may enter when the slot is empty or is being drained.
   assign out_ready = !valid_ff || rsp_ready;
   assign valid_in  = res_valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         item_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
